@@ design/imuoc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset calibration package
// Shared types, constants and helpers for the offset calibration and
// correction block.
// ----------------------------------------------------------------------------
package imuoc_pkg;

   localparam int SENSOR_SLOTS = 8;
   localparam int CAL_SAMPLES  = 100;
   localparam int AXES         = 6;
   localparam int SAMPLE_W     = 16;
   localparam int SUM_W        = 24;
   localparam int MASK_W       = 8;
   localparam int ID_W         = 3;

   localparam int SLOT_W  = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
   localparam int COUNT_W = $clog2(CAL_SAMPLES + 1);

   // Reciprocal of the sample count for the divide by multiplication.
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 31;
   localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'((64'd1 << RECIP_SHIFT) / CAL_SAMPLES);
   localparam int PROD_W      = SUM_W + RECIP_W;

   // Calibration pipeline depth from the completing item to the store write.
   localparam int CAL_STAGES = 5;

   localparam logic signed [SAMPLE_W-1:0] ONE_G_COUNTS = 16'sd16384;

   // Axis positions within a stored offset row.
   localparam int AXIS_AX = 0;
   localparam int AXIS_AY = 1;
   localparam int AXIS_AZ = 2;
   localparam int AXIS_GX = 3;
   localparam int AXIS_GY = 4;
   localparam int AXIS_GZ = 5;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_CAL  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_READ_FAIL   = 2'd1,
      STATUS_CAL_IGNORED = 2'd2
   } status_type;

   typedef logic [AXES-1:0][SAMPLE_W-1:0] axis_row_type;
   typedef logic [AXES-1:0][SUM_W-1:0]    sum_row_type;

   typedef struct packed {
      logic                       kind;
      logic [ID_W-1:0]            sensor_id;
      logic                       bus_ok;
      logic signed [SAMPLE_W-1:0] raw_accel_x;
      logic signed [SAMPLE_W-1:0] raw_accel_y;
      logic signed [SAMPLE_W-1:0] raw_accel_z;
      logic signed [SAMPLE_W-1:0] raw_temp;
      logic signed [SAMPLE_W-1:0] raw_gyro_x;
      logic signed [SAMPLE_W-1:0] raw_gyro_y;
      logic signed [SAMPLE_W-1:0] raw_gyro_z;
   } req_item_type;

   typedef struct packed {
      status_type                 status;
      logic                       calibration_done;
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] temperature;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
   } rsp_item_type;

   // Sample handed to the calibration unit when an item is accepted.
   typedef struct packed {
      logic              take;
      logic              bus_ok;
      logic [SLOT_W-1:0] slot;
      axis_row_type      axis;
   } cal_sample_type;

   typedef struct packed {
      logic busy;
      logic last;
   } cal_status_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      axis_row_type      data;
   } offset_wr_type;

   function automatic axis_row_type item_axes(input req_item_type item);
      axis_row_type row;
      row[AXIS_AX] = item.raw_accel_x;
      row[AXIS_AY] = item.raw_accel_y;
      row[AXIS_AZ] = item.raw_accel_z;
      row[AXIS_GX] = item.raw_gyro_x;
      row[AXIS_GY] = item.raw_gyro_y;
      row[AXIS_GZ] = item.raw_gyro_z;
      return row;
   endfunction

endpackage

@@ design/imuoc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset calibration channels
// Valid/ready channels for raw sample items and corrected result items.
// ----------------------------------------------------------------------------
interface imuoc_req_if;
   logic                   valid;
   logic                   ready;
   imuoc_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface imuoc_rsp_if;
   logic                   valid;
   logic                   ready;
   imuoc_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/imuoc_offset_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset store
// One row of six axis offsets per sensor slot, registered read, with a
// valid bit per row so that rows never written read as zero.
// ----------------------------------------------------------------------------
module imuoc_offset_ram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [imuoc_pkg::SLOT_W-1:0]    rd_addr,
   output imuoc_pkg::axis_row_type         rd_data,
   input  imuoc_pkg::offset_wr_type        wr
);

   imuoc_pkg::axis_row_type mem [imuoc_pkg::SENSOR_SLOTS];

   logic [imuoc_pkg::SENSOR_SLOTS-1:0] row_vld_ff;
   imuoc_pkg::axis_row_type            rd_data_ff;
   logic                               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.slot] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_vld_ff[wr.slot] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ design/imuoc_cal_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibration unit
// Accumulates calibration samples and, on the last one, divides the sums
// by the sample count in a short pipeline and writes the offset row.
// ----------------------------------------------------------------------------
module imuoc_cal_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  imuoc_pkg::cal_sample_type  smp,
   output imuoc_pkg::cal_status_type  stat,
   output imuoc_pkg::offset_wr_type   wr
);

   imuoc_pkg::sum_row_type sums_ff, sums_in;
   logic [imuoc_pkg::COUNT_W-1:0] count_ff;
   logic last;

   logic [imuoc_pkg::CAL_STAGES-1:0] vld_ff;
   logic [imuoc_pkg::SLOT_W-1:0]     slot0_ff, slot1_ff, slot2_ff, slot3_ff, slot4_ff;

   imuoc_pkg::sum_row_type           sum0_ff;
   imuoc_pkg::sum_row_type           mag1_ff, mag1_in;
   logic [imuoc_pkg::AXES-1:0]       neg1_ff, neg2_ff, neg3_ff;
   imuoc_pkg::sum_row_type           mag2_ff;
   logic [imuoc_pkg::AXES-1:0][imuoc_pkg::PROD_W-1:0] prod2_ff, prod2_in;
   imuoc_pkg::sum_row_type           quot3_ff, quot3_in;
   imuoc_pkg::axis_row_type          off4_ff, off4_in;

   assign last = (count_ff == imuoc_pkg::COUNT_W'(imuoc_pkg::CAL_SAMPLES - 1));

   always_comb begin
      for (int k = 0; k < imuoc_pkg::AXES; k++) begin
         sums_in[k] = smp.bus_ok
            ? sums_ff[k] + {{(imuoc_pkg::SUM_W - imuoc_pkg::SAMPLE_W)
                               {smp.axis[k][imuoc_pkg::SAMPLE_W-1]}},
                            smp.axis[k]}
            : sums_ff[k];
      end
   end

   // Accumulators and sample count.
   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff  <= '0;
         count_ff <= '0;
      end else if (smp.take) begin
         if (last) begin
            sums_ff  <= '0;
            count_ff <= '0;
         end else begin
            sums_ff  <= sums_in;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[imuoc_pkg::CAL_STAGES-2:0], smp.take && last};
      end
   end

   function automatic logic [imuoc_pkg::SAMPLE_W-1:0] qs_az(
      input logic [imuoc_pkg::SUM_W-1:0] q,
      input logic                        neg);
      logic [imuoc_pkg::SUM_W-1:0] s;
      s = neg ? (~q + 1'b1) : q;
      return s[imuoc_pkg::SAMPLE_W-1:0] - imuoc_pkg::ONE_G_COUNTS;
   endfunction

   // Magnitude, then multiply by the reciprocal, then a single correction
   // step, so the quotient is truncated toward zero like a signed divide.
   always_comb begin
      logic [imuoc_pkg::SUM_W-1:0] q0;
      logic [imuoc_pkg::SUM_W-1:0] rem;
      logic [imuoc_pkg::SUM_W-1:0] qs;
      for (int k = 0; k < imuoc_pkg::AXES; k++) begin
         mag1_in[k]  = sum0_ff[k][imuoc_pkg::SUM_W-1] ? (~sum0_ff[k] + 1'b1) : sum0_ff[k];
         prod2_in[k] = mag1_ff[k] * imuoc_pkg::RECIP_VAL;
         q0          = imuoc_pkg::SUM_W'(prod2_ff[k] >> imuoc_pkg::RECIP_SHIFT);
         rem         = mag2_ff[k] - imuoc_pkg::SUM_W'(q0 * imuoc_pkg::CAL_SAMPLES);
         quot3_in[k] = (rem >= imuoc_pkg::SUM_W'(imuoc_pkg::CAL_SAMPLES)) ? q0 + 1'b1 : q0;
         qs          = neg3_ff[k] ? (~quot3_ff[k] + 1'b1) : quot3_ff[k];
         off4_in[k]  = qs[imuoc_pkg::SAMPLE_W-1:0];
      end
      off4_in[imuoc_pkg::AXIS_AZ] = qs_az(quot3_ff[imuoc_pkg::AXIS_AZ],
                                          neg3_ff[imuoc_pkg::AXIS_AZ]);
   end

   always_ff @(posedge clock) begin
      if (smp.take && last) begin
         sum0_ff  <= sums_in;
         slot0_ff <= smp.slot;
      end
      for (int k = 0; k < imuoc_pkg::AXES; k++) begin
         neg1_ff[k] <= sum0_ff[k][imuoc_pkg::SUM_W-1];
      end
      mag1_ff  <= mag1_in;
      slot1_ff <= slot0_ff;
      prod2_ff <= prod2_in;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      slot2_ff <= slot1_ff;
      quot3_ff <= quot3_in;
      neg3_ff  <= neg2_ff;
      slot3_ff <= slot2_ff;
      off4_ff  <= off4_in;
      slot4_ff <= slot3_ff;
   end

   assign stat.busy = |vld_ff;
   assign stat.last = last;

   assign wr.en   = vld_ff[imuoc_pkg::CAL_STAGES-1];
   assign wr.slot = slot4_ff;
   assign wr.data = off4_ff;

endmodule

@@ design/imu_offset_calibrate_correct_top.sv @@
`timescale 1ns / 1ps
// An accepted item passes stage s1 and the result register before it is offered.
// Throughput: one item per cycle, set by the single read port of the offset store,
// while the output is not stalled; after an item that completes calibration, input
// is held off while the divide pipeline computes the offsets and writes the store.
// Reset (synchronous) clears the mask, accumulators, count, pipeline valids
// and the store's row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// IMU offset calibration and correction
// Subtracts stored per-sensor offsets from raw frames and computes new
// offsets from averaged calibration frames.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_correct_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [imuoc_pkg::MASK_W-1:0]     csr_wr_data,
   imuoc_req_if.sink                        req_chan,
   imuoc_rsp_if.source                      rsp_chan
);

   logic [imuoc_pkg::MASK_W-1:0] mask_ff;

   imuoc_pkg::req_item_type   item;
   logic                      accept;
   logic                      slot_ok;
   imuoc_pkg::status_type     status_in;
   logic                      done_in;

   imuoc_pkg::cal_sample_type smp;
   imuoc_pkg::cal_status_type cal_stat;
   imuoc_pkg::offset_wr_type  wr;
   imuoc_pkg::axis_row_type   offs;

   logic                      s1_vld_ff;
   imuoc_pkg::req_item_type   s1_item_ff;
   imuoc_pkg::status_type     s1_status_ff;
   logic                      s1_done_ff;
   logic                      s1_adv;

   logic                      rsp_vld_ff;
   imuoc_pkg::rsp_item_type   rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   assign item    = req_chan.data;
   assign s1_adv  = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !cal_stat.busy && (!s1_vld_ff || s1_adv);
   assign accept  = req_chan.valid && req_chan.ready;
   assign slot_ok = (int'(item.sensor_id) < imuoc_pkg::SENSOR_SLOTS) && mask_ff[item.sensor_id];

   always_comb begin
      if (item.kind == imuoc_pkg::KIND_READ) begin
         status_in = (slot_ok && item.bus_ok) ? imuoc_pkg::STATUS_OK
                                              : imuoc_pkg::STATUS_READ_FAIL;
      end else begin
         status_in = slot_ok ? imuoc_pkg::STATUS_OK : imuoc_pkg::STATUS_CAL_IGNORED;
      end
      done_in = (item.kind == imuoc_pkg::KIND_CAL) && slot_ok && cal_stat.last;
   end

   always_comb begin
      smp.take   = accept && (item.kind == imuoc_pkg::KIND_CAL) && slot_ok;
      smp.bus_ok = item.bus_ok;
      smp.slot   = imuoc_pkg::SLOT_W'(item.sensor_id);
      smp.axis   = imuoc_pkg::item_axes(item);
   end

   imuoc_cal_unit u_cal (
      .clock (clock),
      .reset (reset),
      .smp   (smp),
      .stat  (cal_stat),
      .wr    (wr)
   );

   // The store is read as the item is accepted; the row arrives with it in
   // the next stage.
   imuoc_offset_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (imuoc_pkg::SLOT_W'(item.sensor_id)),
      .rd_data (offs),
      .wr      (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= item;
         s1_status_ff <= status_in;
         s1_done_ff   <= done_in;
      end
   end

   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in.status           = s1_status_ff;
      rsp_data_in.calibration_done = s1_done_ff;
      if ((s1_item_ff.kind == imuoc_pkg::KIND_READ) && (s1_status_ff == imuoc_pkg::STATUS_OK)) begin
         rsp_data_in.accel_x     = s1_item_ff.raw_accel_x - offs[imuoc_pkg::AXIS_AX];
         rsp_data_in.accel_y     = s1_item_ff.raw_accel_y - offs[imuoc_pkg::AXIS_AY];
         rsp_data_in.accel_z     = s1_item_ff.raw_accel_z - offs[imuoc_pkg::AXIS_AZ];
         rsp_data_in.temperature = s1_item_ff.raw_temp;
         rsp_data_in.gyro_x      = s1_item_ff.raw_gyro_x - offs[imuoc_pkg::AXIS_GX];
         rsp_data_in.gyro_y      = s1_item_ff.raw_gyro_y - offs[imuoc_pkg::AXIS_GY];
         rsp_data_in.gyro_z      = s1_item_ff.raw_gyro_z - offs[imuoc_pkg::AXIS_GZ];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
